FILE: src/camera_transform_clip_project_assert.svh
// assertion helpers for the checker of the camera transform block
`ifndef CAMERA_TRANSFORM_CLIP_PROJECT_ASSERT_SVH
`define CAMERA_TRANSFORM_CLIP_PROJECT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CTCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define CTCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ctcp_pkg.sv
package ctcp_pkg;

  localparam int SCREEN_W_DEF = 640;
  localparam int SCREEN_H_DEF = 480;

  // camera-space coordinate, Q17.16
  localparam int CRD_W = 33;
  localparam logic signed [CRD_W-1:0] NEAR_Z    = 33'sd6554;
  localparam logic signed [CRD_W-1:0] COORD_MAX = 33'sd4294967295;
  localparam logic signed [31:0]      TRIG_MAX  = 32'sd1073741824;

  // clip fraction and projection quotient widths
  localparam int CLIP_QW = 30;
  localparam int PQ_W    = 27;
  localparam int DEN_W   = 40;
  localparam logic [PQ_W-1:0] QCAP = 27'd67108864;

  localparam logic signed [23:0] OUT_MAX = 24'sd8388607;
  localparam logic signed [23:0] OUT_MIN = -24'sd8388608;

  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAM_POS_X,
    CFG_CAM_POS_Y,
    CFG_CAM_POS_Z,
    CFG_YAW_COS,
    CFG_YAW_SIN,
    CFG_PITCH_COS,
    CFG_PITCH_SIN,
    CFG_VIEW_SCALE
  } cfg_idx_t;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef struct packed {
    crd_t x;
    crd_t y;
    crd_t z;
  } vec_t;

  typedef struct packed {
    logic signed [31:0] yc;
    logic signed [31:0] ys;
    logic signed [31:0] pc;
    logic signed [31:0] ps;
  } trig_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } in_t;

  typedef struct packed {
    logic               prim_kind;
    logic signed [23:0] screen_x0;
    logic signed [23:0] screen_y0;
    logic signed [23:0] screen_x1;
    logic signed [23:0] screen_y1;
  } out_t;

  // floor(s / 2^30), saturated to +-(2^32-1)
  function automatic crd_t rot_sat(input logic signed [65:0] s);
    logic signed [35:0] f;
    f = 36'(s >>> 30);
    if (f > 36'sd4294967295) begin
      return COORD_MAX;
    end else if (f < -36'sd4294967295) begin
      return -COORD_MAX;
    end
    return 33'(f);
  endfunction

  function automatic logic signed [31:0] trig_clamp(input logic signed [31:0] v);
    if (v > TRIG_MAX) begin
      return TRIG_MAX;
    end else if (v < -TRIG_MAX) begin
      return -TRIG_MAX;
    end
    return v;
  endfunction

  function automatic logic signed [23:0] out_clamp(input logic signed [28:0] v);
    if (v > 29'(OUT_MAX)) begin
      return OUT_MAX;
    end else if (v < 29'(OUT_MIN)) begin
      return OUT_MIN;
    end
    return 24'(v);
  endfunction

endpackage

FILE: src/ctcp_div.sv
// restoring divider, one quotient bit per register stage
module ctcp_div #(
  parameter int DW = 40,
  parameter int QW = 27,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] r_r [QW];
  logic [QW-1:0] l_r [QW];
  logic [QW-1:0] q_r [QW];
  logic [DW-1:0] d_r [QW];
  logic [SW-1:0] s_r [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stg
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] l_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   sh;
    logic          ge;

    if (g == 0) begin : g_head
      assign r_in = rem_i;
      assign d_in = den_i;
      assign l_in = low_i;
      assign q_in = '0;
      assign s_in = side_i;
    end else begin : g_body
      assign r_in = r_r[g-1];
      assign d_in = d_r[g-1];
      assign l_in = l_r[g-1];
      assign q_in = q_r[g-1];
      assign s_in = s_r[g-1];
    end

    assign sh = {r_in, l_in[QW-1]};
    assign ge = (sh >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (adv) begin
        r_r[g] <= ge ? DW'(sh - {1'b0, d_in}) : sh[DW-1:0];
        l_r[g] <= {l_in[QW-2:0], 1'b0};
        q_r[g] <= {q_in[QW-2:0], ge};
        d_r[g] <= d_in;
        s_r[g] <= s_in;
      end
    end
  end

  assign quot_o = q_r[QW-1];
  assign side_o = s_r[QW-1];

endmodule

FILE: src/ctcp_xform.sv
// yaw then pitch rotation of one camera-relative vertex, four stages
module ctcp_xform (
  input  logic            clk,
  input  logic            adv,
  input  ctcp_pkg::vec_t  d_i,
  input  ctcp_pkg::trig_t trig_i,
  output ctcp_pkg::vec_t  v_o
);

  logic signed [64:0]  p1_r [4];
  ctcp_pkg::crd_t      dy1_r;
  ctcp_pkg::crd_t      rx2_r;
  ctcp_pkg::crd_t      rz2_r;
  ctcp_pkg::crd_t      dy2_r;
  logic signed [64:0]  p3_r [4];
  ctcp_pkg::crd_t      rx3_r;
  ctcp_pkg::vec_t      v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      // yaw products
      p1_r[0] <= d_i.x * trig_i.yc;
      p1_r[1] <= d_i.z * trig_i.ys;
      p1_r[2] <= d_i.x * trig_i.ys;
      p1_r[3] <= d_i.z * trig_i.yc;
      dy1_r   <= d_i.y;
      // yaw sums
      rx2_r   <= ctcp_pkg::rot_sat(66'(p1_r[0]) - 66'(p1_r[1]));
      rz2_r   <= ctcp_pkg::rot_sat(66'(p1_r[2]) + 66'(p1_r[3]));
      dy2_r   <= dy1_r;
      // pitch products
      p3_r[0] <= dy2_r * trig_i.pc;
      p3_r[1] <= rz2_r * trig_i.ps;
      p3_r[2] <= dy2_r * trig_i.ps;
      p3_r[3] <= rz2_r * trig_i.pc;
      rx3_r   <= rx2_r;
      // pitch sums
      v_r.x   <= rx3_r;
      v_r.y   <= ctcp_pkg::rot_sat(66'(p3_r[0]) - 66'(p3_r[1]));
      v_r.z   <= ctcp_pkg::rot_sat(66'(p3_r[2]) + 66'(p3_r[3]));
    end
  end

  assign v_o = v_r;

endmodule

FILE: src/camera_transform_clip_project.sv
// Camera transform, near-plane clip and perspective projection. One point or
// line word is taken per clock while in_stall is low and zero or one result
// word comes out for it; a culled primitive simply leaves no word. The pipeline
// runs as one piece: while a result word sits in the output register with
// out_stall high, every stage holds and in_stall is raised, otherwise a new word
// enters each cycle. Most of the pipeline is the two pipelined restoring
// dividers, 30 stages for the near-plane clip fraction and 27 for the projection
// quotient, plus four stages of yaw/pitch multiply-accumulate. Configuration
// registers are written on cfg_valid (cfg_ready is always high) and must only
// change while no word is in flight.
module camera_transform_clip_project #(
  parameter int SCREEN_W = ctcp_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = ctcp_pkg::SCREEN_H_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ctcp_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ctcp_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ctcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  // view_scale * SCREEN_H and its split for two narrow multipliers
  localparam int MW = 24 + $clog2(SCREEN_H + 1);
  localparam int ML = 18;
  localparam int MH = MW - ML;
  localparam int PW = 32 + MW;
  localparam int HW = (PW - ctcp_pkg::PQ_W > ctcp_pkg::DEN_W) ?
                      PW - ctcp_pkg::PQ_W : ctcp_pkg::DEN_W;
  localparam int CX = SCREEN_W * 128;
  localparam int CY = SCREEN_H * 128;

  // stage map: 0 entry, 1..4 rotate, C0 classify, clip divide, I1/I2 interp,
  // P0..P3 projection setup, projection divide
  localparam int ST_C0   = 5;
  localparam int ST_I1   = ST_C0 + ctcp_pkg::CLIP_QW + 1;
  localparam int ST_I2   = ST_I1 + 1;
  localparam int ST_P3   = ST_I2 + 4;
  localparam int ST_LAST = ST_P3 + ctcp_pkg::PQ_W;
  localparam int NST     = ST_LAST + 1;

  typedef struct packed {
    logic vld;
    logic line;
    logic clip;
    logic bsel;
  } ctl_t;

  typedef struct packed {
    ctcp_pkg::vec_t     b;
    ctcp_pkg::vec_t     f;
    logic signed [33:0] dlx;
    logic signed [33:0] dly;
  } clip_side_t;

  // ---------------------------------------------------------------- config
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic signed [31:0] yaw_cos_r, yaw_sin_r, pitch_cos_r, pitch_sin_r;
  logic [23:0]        view_scale_r;
  ctcp_pkg::trig_t    trig_r;
  logic [MW-1:0]      m_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r      <= '0;
      cam_y_r      <= '0;
      cam_z_r      <= '0;
      yaw_cos_r    <= ctcp_pkg::TRIG_MAX;
      yaw_sin_r    <= '0;
      pitch_cos_r  <= ctcp_pkg::TRIG_MAX;
      pitch_sin_r  <= '0;
      view_scale_r <= 24'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ctcp_pkg::CFG_CAM_POS_X:  cam_x_r      <= cfg_data;
        ctcp_pkg::CFG_CAM_POS_Y:  cam_y_r      <= cfg_data;
        ctcp_pkg::CFG_CAM_POS_Z:  cam_z_r      <= cfg_data;
        ctcp_pkg::CFG_YAW_COS:    yaw_cos_r    <= cfg_data;
        ctcp_pkg::CFG_YAW_SIN:    yaw_sin_r    <= cfg_data;
        ctcp_pkg::CFG_PITCH_COS:  pitch_cos_r  <= cfg_data;
        ctcp_pkg::CFG_PITCH_SIN:  pitch_sin_r  <= cfg_data;
        ctcp_pkg::CFG_VIEW_SCALE: view_scale_r <= cfg_data[23:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // clamped trig and scale product, refreshed every cycle from the registers
  always_ff @(posedge clk) begin
    trig_r.yc <= ctcp_pkg::trig_clamp(yaw_cos_r);
    trig_r.ys <= ctcp_pkg::trig_clamp(yaw_sin_r);
    trig_r.pc <= ctcp_pkg::trig_clamp(pitch_cos_r);
    trig_r.ps <= ctcp_pkg::trig_clamp(pitch_sin_r);
    m_r       <= MW'(view_scale_r) * MW'(SCREEN_H);
  end

  // ---------------------------------------------------------------- flow
  logic   adv;
  logic   out_valid_r;
  ctcp_pkg::out_t out_data_r;

  // whole pipe moves unless the held output word is blocked
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  ctl_t ctl_r   [NST];
  ctl_t ctl_nxt [NST];

  // ---------------------------------------------------------------- entry
  ctcp_pkg::vec_t ds_r, de_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_r.x <= 33'(in_data.start_x) - 33'(cam_x_r);
      ds_r.y <= 33'(in_data.start_y) - 33'(cam_y_r);
      ds_r.z <= 33'(in_data.start_z) - 33'(cam_z_r);
      de_r.x <= 33'(in_data.end_x) - 33'(cam_x_r);
      de_r.y <= 33'(in_data.end_y) - 33'(cam_y_r);
      de_r.z <= 33'(in_data.end_z) - 33'(cam_z_r);
    end
  end

  // ---------------------------------------------------------------- rotate
  ctcp_pkg::vec_t xs, xe;

  ctcp_xform u_xform_s (
    .clk    (clk),
    .adv    (adv),
    .d_i    (ds_r),
    .trig_i (trig_r),
    .v_o    (xs)
  );

  ctcp_xform u_xform_e (
    .clk    (clk),
    .adv    (adv),
    .d_i    (de_r),
    .trig_i (trig_r),
    .v_o    (xe)
  );

  // ---------------------------------------------------------------- classify
  logic           sb, eb, keep, clip;
  ctcp_pkg::vec_t cb, cf;
  clip_side_t     cside_r;
  logic [32:0]    num_r, den_r;

  always_comb begin
    sb   = (xs.z <= ctcp_pkg::NEAR_Z);
    eb   = (xe.z <= ctcp_pkg::NEAR_Z);
    keep = ctl_r[ST_C0-1].line ? !(sb && eb) : !sb;
    clip = ctl_r[ST_C0-1].line && (sb != eb);
    // b is the end that may move, f the end that stays
    cb   = sb ? xs : xe;
    cf   = sb ? xe : xs;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cside_r.b   <= cb;
      cside_r.f   <= cf;
      cside_r.dlx <= 34'(cf.x) - 34'(cb.x);
      cside_r.dly <= 34'(cf.y) - 34'(cb.y);
      num_r       <= clip ? 33'(ctcp_pkg::NEAR_Z - cb.z) : 33'd0;
      den_r       <= clip ? 33'(cf.z - cb.z) : 33'd1;
    end
  end

  // control pipe: flags ride alongside the data
  always_comb begin
    for (int k = 0; k < NST; k++) begin
      if (k == 0) begin
        ctl_nxt[k] = '{vld: in_valid, line: in_data.req_type, clip: 1'b0, bsel: 1'b0};
      end else begin
        ctl_nxt[k] = ctl_r[k-1];
      end
    end
    ctl_nxt[ST_C0].vld  = ctl_r[ST_C0-1].vld && keep;
    ctl_nxt[ST_C0].clip = clip;
    ctl_nxt[ST_C0].bsel = sb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (adv) begin
      for (int k = 0; k < NST; k++) begin
        ctl_r[k] <= ctl_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------- clip divide
  // t = (NEAR_Z - zb) * 2^30 / (zf - zb), always below 2^30
  logic [ctcp_pkg::CLIP_QW-1:0] t_q;
  clip_side_t                   cside_q;

  ctcp_div #(
    .DW (33),
    .QW (ctcp_pkg::CLIP_QW),
    .SW ($bits(clip_side_t))
  ) u_clip_div (
    .clk    (clk),
    .adv    (adv),
    .rem_i  (num_r),
    .low_i  ('0),
    .den_i  (den_r),
    .side_i (cside_r),
    .quot_o (t_q),
    .side_o (cside_q)
  );

  // ---------------------------------------------------------------- interp
  logic signed [64:0] pix_r, piy_r;
  clip_side_t         iside_r;
  ctcp_pkg::crd_t     nbx, nby;
  ctcp_pkg::vec_t     bnew;
  ctcp_pkg::vec_t     vs_r, ve_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_r   <= cside_q.dlx * $signed({1'b0, t_q});
      piy_r   <= cside_q.dly * $signed({1'b0, t_q});
      iside_r <= cside_q;
    end
  end

  always_comb begin
    nbx  = 33'(36'(iside_r.b.x) + 36'(pix_r >>> 30));
    nby  = 33'(36'(iside_r.b.y) + 36'(piy_r >>> 30));
    bnew = iside_r.b;
    if (ctl_r[ST_I1].clip) begin
      bnew = '{x: nbx, y: nby, z: ctcp_pkg::NEAR_Z};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vs_r <= ctl_r[ST_I1].bsel ? bnew : iside_r.f;
      ve_r <= ctl_r[ST_I1].bsel ? iside_r.f : bnew;
    end
  end

  // ---------------------------------------------------------------- projection
  // lanes: 0 start x, 1 start y, 2 end x, 3 end y
  ctcp_pkg::crd_t             crd [4];
  logic [31:0]                a0_r  [4];
  logic                       ng0_r [4];
  logic                       ng1_r [4];
  logic                       ng2_r [4];
  logic                       ng3_r [4];
  logic [ctcp_pkg::DEN_W-1:0] d0_r [2];
  logic [ctcp_pkg::DEN_W-1:0] d1_r [2];
  logic [ctcp_pkg::DEN_W-1:0] d2_r [2];
  logic [ctcp_pkg::DEN_W-1:0] d3_r [2];
  logic [32+ML-1:0]           pl_r [4];
  logic [32+MH-1:0]           ph_r [4];
  logic [PW-1:0]              pp_r [4];
  logic [HW-1:0]              hi   [4];
  logic [ctcp_pkg::DEN_W-1:0] rem_r [4];
  logic [ctcp_pkg::PQ_W-1:0]  low_r [4];
  logic                       ovf_r [4];

  always_comb begin
    crd[0] = vs_r.x;
    crd[1] = vs_r.y;
    crd[2] = ve_r.x;
    crd[3] = ve_r.y;
    for (int j = 0; j < 4; j++) begin
      hi[j] = HW'(pp_r[j] >> ctcp_pkg::PQ_W);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        // P0: magnitude and sign
        a0_r[j]  <= crd[j][32] ? 32'(-crd[j]) : crd[j][31:0];
        ng0_r[j] <= crd[j][32];
        // P1: partial products of |c| * view_scale * SCREEN_H
        pl_r[j]  <= (32+ML)'(a0_r[j]) * (32+ML)'(m_r[ML-1:0]);
        ph_r[j]  <= (32+MH)'(a0_r[j]) * (32+MH)'(m_r[MW-1:ML]);
        ng1_r[j] <= ng0_r[j];
        // P2: full product
        pp_r[j]  <= PW'(pl_r[j]) + (PW'(ph_r[j]) << ML);
        ng2_r[j] <= ng1_r[j];
        // P3: quotient would exceed 27 bits, and divider seed
        ovf_r[j] <= (hi[j] >= HW'(d2_r[j/2]));
        rem_r[j] <= hi[j][ctcp_pkg::DEN_W-1:0];
        low_r[j] <= pp_r[j][ctcp_pkg::PQ_W-1:0];
        ng3_r[j] <= ng2_r[j];
      end
      // divisor is z * 256, z known positive here
      d0_r[0] <= {vs_r.z[31:0], 8'h00};
      d0_r[1] <= {ve_r.z[31:0], 8'h00};
      for (int v = 0; v < 2; v++) begin
        d1_r[v] <= d0_r[v];
        d2_r[v] <= d1_r[v];
        d3_r[v] <= d2_r[v];
      end
    end
  end

  logic [ctcp_pkg::PQ_W-1:0] quot_w [4];
  logic [1:0]                pside_w [4];

  for (genvar j = 0; j < 4; j++) begin : g_lane
    ctcp_div #(
      .DW (ctcp_pkg::DEN_W),
      .QW (ctcp_pkg::PQ_W),
      .SW (2)
    ) u_proj_div (
      .clk    (clk),
      .adv    (adv),
      .rem_i  (rem_r[j]),
      .low_i  (low_r[j]),
      .den_i  (d3_r[j/2]),
      .side_i ({ovf_r[j], ng3_r[j]}),
      .quot_o (quot_w[j]),
      .side_o (pside_w[j])
    );
  end

  // ---------------------------------------------------------------- result
  logic [ctcp_pkg::PQ_W-1:0] q     [4];
  logic signed [28:0]        scr   [4];
  logic                      add_q [4];
  ctcp_pkg::out_t            out_nxt;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (pside_w[j][1] || (quot_w[j] > ctcp_pkg::QCAP)) begin
        q[j] = ctcp_pkg::QCAP;
      end else begin
        q[j] = quot_w[j];
      end
      // x moves right for positive x, y moves up (smaller) for positive y
      add_q[j] = (j % 2 == 1) ? pside_w[j][0] : !pside_w[j][0];
      if (add_q[j]) begin
        scr[j] = ((j % 2 == 1) ? 29'(CY) : 29'(CX)) + $signed({2'b00, q[j]});
      end else begin
        scr[j] = ((j % 2 == 1) ? 29'(CY) : 29'(CX)) - $signed({2'b00, q[j]});
      end
    end
    out_nxt.prim_kind = ctl_r[ST_LAST].line;
    out_nxt.screen_x0 = ctcp_pkg::out_clamp(scr[0]);
    out_nxt.screen_y0 = ctcp_pkg::out_clamp(scr[1]);
    out_nxt.screen_x1 = ctl_r[ST_LAST].line ? ctcp_pkg::out_clamp(scr[2]) : '0;
    out_nxt.screen_y1 = ctl_r[ST_LAST].line ? ctcp_pkg::out_clamp(scr[3]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_r[ST_LAST].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/ctcp_checker.sv
`include "camera_transform_clip_project_assert.svh"

module ctcp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input ctcp_pkg::in_t                  in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input ctcp_pkg::out_t                 out_data,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [ctcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]                    cfg_data
);

  // held result word keeps its payload
  `CTCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result word changed while stalled")

  // input only backs up behind a blocked result word
  `CTCP_ASSERT_NOW(a_in_stall, in_stall, out_valid && out_stall, "input stalled with free output")

  // point words carry no second vertex
  `CTCP_ASSERT_NOW(a_point_zero, out_valid && !out_data.prim_kind, (out_data.screen_x1 == 24'sd0) && (out_data.screen_y1 == 24'sd0), "point word with nonzero second vertex")

  // nothing comes out right after reset
  `CTCP_ASSERT_NOW(a_rst_empty, $rose(rst_n), !out_valid, "result word right after reset")

endmodule

bind camera_transform_clip_project ctcp_checker u_ctcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

FILE: tb/ctcp_checker.sv
module ctcp_scoreboard #(
  parameter int SCREEN_W = ctcp_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = ctcp_pkg::SCREEN_H_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  ctcp_pkg::in_t                  in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  ctcp_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ctcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  localparam longint NEAR = 6554;
  localparam longint CMAX = 64'sd4294967295;
  localparam longint TMAX = 64'sd1073741824;
  localparam longint QLIM = 64'sd67108864;

  // shadow of the camera registers
  longint cam_x, cam_y, cam_z;
  longint yaw_c, yaw_s, pit_c, pit_s;
  longint fov;

  ctcp_pkg::out_t screen_q[$];

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor((a*p + b*q) / 2^30), saturated to the camera-space range
  function automatic longint rotate(longint a, longint p, longint b, longint q);
    wide_t s;
    s = (wide_t'(a) * p + wide_t'(b) * q) >>> 30;
    if (s > CMAX) begin
      return CMAX;
    end else if (s < -CMAX) begin
      return -CMAX;
    end
    return longint'(s);
  endfunction

  task automatic to_camera(input longint x, y, z, output longint v[3]);
    longint yc, ys, pc, ps, dx, dy, dz, rz;
    yc = clampl(yaw_c, -TMAX, TMAX);
    ys = clampl(yaw_s, -TMAX, TMAX);
    pc = clampl(pit_c, -TMAX, TMAX);
    ps = clampl(pit_s, -TMAX, TMAX);
    dx = x - cam_x;
    dy = y - cam_y;
    dz = z - cam_z;
    v[0] = rotate(dx, yc, dz, -ys);
    rz   = rotate(dx, ys, dz, yc);
    v[1] = rotate(dy, pc, rz, -ps);
    v[2] = rotate(dy, ps, rz, pc);
  endtask

  // slide the end behind the near plane along the line onto it
  task automatic clip_near(inout longint b[3], input longint f[3]);
    wide_t t;
    t = (wide_t'(NEAR - b[2]) <<< 30) / wide_t'(f[2] - b[2]);
    b[0] = b[0] + longint'((wide_t'(f[0] - b[0]) * t) >>> 30);
    b[1] = b[1] + longint'((wide_t'(f[1] - b[1]) * t) >>> 30);
    b[2] = NEAR;
  endtask

  function automatic longint persp(longint a, longint d);
    wide_t q;
    q = (wide_t'(a < 0 ? -a : a) * (fov * SCREEN_H)) / wide_t'(d);
    if (q > QLIM) begin
      q = QLIM;
    end
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  task automatic to_screen(input longint v[3], output logic [23:0] sx, sy);
    longint d;
    d  = v[2] * 256;
    sx = 24'(clampl(SCREEN_W * 128 + persp(v[0], d), -8388608, 8388607));
    sy = 24'(clampl(SCREEN_H * 128 - persp(v[1], d), -8388608, 8388607));
  endtask

  task automatic predict(input ctcp_pkg::in_t w);
    longint s[3], e[3];
    ctcp_pkg::out_t r;
    to_camera(w.start_x, w.start_y, w.start_z, s);
    r = '0;
    if (!w.req_type) begin
      if (s[2] > NEAR) begin
        to_screen(s, r.screen_x0, r.screen_y0);
        screen_q.push_back(r);
      end
    end else begin
      to_camera(w.end_x, w.end_y, w.end_z, e);
      if (s[2] > NEAR || e[2] > NEAR) begin
        if (s[2] <= NEAR) begin
          clip_near(s, e);
        end else if (e[2] <= NEAR) begin
          clip_near(e, s);
        end
        r.prim_kind = 1'b1;
        to_screen(s, r.screen_x0, r.screen_y0);
        to_screen(e, r.screen_x1, r.screen_y1);
        screen_q.push_back(r);
      end
    end
  endtask

  task automatic note(input string f, input longint exp, input longint act, inout bit bad);
    bad = 1'b1;
    errors++;
    if (errors <= 10) begin
      $display("mismatch %s: expected %0d actual %0d", f, exp, act);
    end
  endtask

  always @(posedge clk) begin
    ctcp_pkg::out_t x;
    bit bad;
    if (!rst_n) begin
      cam_x <= 0;
      cam_y <= 0;
      cam_z <= 0;
      yaw_c <= TMAX;
      yaw_s <= 0;
      pit_c <= TMAX;
      pit_s <= 0;
      fov   <= 65536;
      screen_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ctcp_pkg::CFG_CAM_POS_X:  cam_x = longint'($signed(cfg_data));
          ctcp_pkg::CFG_CAM_POS_Y:  cam_y = longint'($signed(cfg_data));
          ctcp_pkg::CFG_CAM_POS_Z:  cam_z = longint'($signed(cfg_data));
          ctcp_pkg::CFG_YAW_COS:    yaw_c = longint'($signed(cfg_data));
          ctcp_pkg::CFG_YAW_SIN:    yaw_s = longint'($signed(cfg_data));
          ctcp_pkg::CFG_PITCH_COS:  pit_c = longint'($signed(cfg_data));
          ctcp_pkg::CFG_PITCH_SIN:  pit_s = longint'($signed(cfg_data));
          ctcp_pkg::CFG_VIEW_SCALE: fov   = longint'(cfg_data[23:0]);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (screen_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result word %h", out_data);
          end
        end else begin
          x = screen_q.pop_front();
          bad = 1'b0;
          if (out_data.prim_kind != x.prim_kind)
            note("prim_kind", x.prim_kind, out_data.prim_kind, bad);
          if (out_data.screen_x0 != x.screen_x0)
            note("screen_x0", x.screen_x0, out_data.screen_x0, bad);
          if (out_data.screen_y0 != x.screen_y0)
            note("screen_y0", x.screen_y0, out_data.screen_y0, bad);
          if (out_data.screen_x1 != x.screen_x1)
            note("screen_x1", x.screen_x1, out_data.screen_x1, bad);
          if (out_data.screen_y1 != x.screen_y1)
            note("screen_y1", x.screen_y1, out_data.screen_y1, bad);
        end
      end
      if (in_valid && !in_stall) begin
        predict(in_data);
      end
    end
    pending <= screen_q.size();
  end

endmodule

FILE: tb/tb_camera_transform_clip_project.sv
module tb_camera_transform_clip_project;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     ITEMS      = 1150;
  localparam int     DRAIN      = 100;   // longer than the pipeline depth
  localparam longint CYCLE_CAP  = 600000;
  localparam logic [ctcp_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = '1;  // no register behind it
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] NEAR_Q16 = 32'd6554;
  localparam logic [31:0] TRIG_ONE = 32'h4000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ctcp_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ctcp_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ctcp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int errors;
  int pending;
  longint cycles = 0;

  // idling mode: 0 none, 1 sender gaps, 2 receiver stalls, 3 both light
  int idle_mode = 0;
  // current camera position, used to aim random geometry at the camera
  int cam_x = 0, cam_y = 0, cam_z = 0;

  always #2 clk = ~clk;

  camera_transform_clip_project dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ctcp_scoreboard chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver back-pressure, changed only at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case (idle_mode)
        2:       out_stall <= ($urandom_range(0, 99) < 72);
        3:       out_stall <= ($urandom_range(0, 99) < 11);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // entered and left at a falling edge
  task automatic send_word(input ctcp_pkg::in_t w);
    int pct;
    pct = idle_mode == 1 ? 72 : (idle_mode == 3 ? 11 : 0);
    while ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic reg_write(input logic [ctcp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    case (idx)
      ctcp_pkg::CFG_CAM_POS_X: cam_x = val;
      ctcp_pkg::CFG_CAM_POS_Y: cam_y = val;
      ctcp_pkg::CFG_CAM_POS_Z: cam_z = val;
      default: ;
    endcase
  endtask

  // let in-flight words drain; culled ones leave no trace, so wait out the pipe
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic load_camera(input logic [31:0] px, py, pz, yc, ys, pc, ps, vs);
    reg_write(ctcp_pkg::CFG_CAM_POS_X, px);
    reg_write(ctcp_pkg::CFG_CAM_POS_Y, py);
    reg_write(ctcp_pkg::CFG_CAM_POS_Z, pz);
    reg_write(ctcp_pkg::CFG_YAW_COS, yc);
    reg_write(ctcp_pkg::CFG_YAW_SIN, ys);
    reg_write(ctcp_pkg::CFG_PITCH_COS, pc);
    reg_write(ctcp_pkg::CFG_PITCH_SIN, ps);
    reg_write(ctcp_pkg::CFG_VIEW_SCALE, vs);
  endtask

  function automatic logic [31:0] rand_trig();
    int v;
    v = $urandom_range(0, 1 << 30);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // coordinate near the camera with a random magnitude
  function automatic logic [31:0] near_coord(input int base, input bit ahead);
    int off;
    off = $signed($urandom) >>> $urandom_range(1, 24);
    if (ahead && off < 0) begin
      off = -off;
    end
    return base + off;
  endfunction

  function automatic ctcp_pkg::in_t rand_word();
    ctcp_pkg::in_t w;
    logic [223:0] raw;
    int pick;
    pick = $urandom_range(0, 9);
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(ctcp_pkg::in_t)-1:0];
    if (pick != 0) begin
      // well-formed geometry mostly in front, some ends swung behind
      w.start_x = near_coord(cam_x, 1'b0);
      w.start_y = near_coord(cam_y, 1'b0);
      w.start_z = near_coord(cam_z, pick > 2);
      w.end_x   = near_coord(cam_x, 1'b0);
      w.end_y   = near_coord(cam_y, 1'b0);
      w.end_z   = near_coord(cam_z, pick > 5);
      w.req_type = (pick > 3);
    end
    return w;
  endfunction

  function automatic ctcp_pkg::in_t mk(input logic t, input logic [31:0] sx, sy, sz, ex, ey, ez);
    ctcp_pkg::in_t w;
    w.req_type = t;
    w.start_x = sx; w.start_y = sy; w.start_z = sz;
    w.end_x = ex;   w.end_y = ey;   w.end_z = ez;
    return w;
  endfunction

  initial begin
    int phase;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words at the reset camera (identity view, scale one)
    send_word(mk(0, 0, 0, ONE_Q16, 0, 0, 0));                    // dead center
    send_word(mk(0, ONE_Q16, -ONE_Q16, 2 * ONE_Q16, '1, '1, '1)); // point, end fields junk
    send_word(mk(0, 0, 0, NEAR_Q16, 0, 0, 0));                   // on the plane: culled
    send_word(mk(0, ONE_Q16, ONE_Q16, NEAR_Q16 + 1, 0, 0, 0));   // just in front
    send_word(mk(0, 0, 0, -ONE_Q16, 0, 0, 0));                   // behind
    send_word(mk(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
    send_word(mk(0, 32'h8000_0000, 32'h7FFF_FFFF, NEAR_Q16 + 1, 0, 0, 0)); // quotient cap
    send_word(mk(0, '1, '1, '1, '1, '1, '1));
    send_word(mk(1, -ONE_Q16, 0, ONE_Q16, ONE_Q16, ONE_Q16, 3 * ONE_Q16)); // both in front
    send_word(mk(1, 0, 0, -ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16));  // start behind
    send_word(mk(1, ONE_Q16, 0, 4 * ONE_Q16, 0, -ONE_Q16, 0));    // end behind
    send_word(mk(1, 0, 0, -ONE_Q16, 0, 0, NEAR_Q16));             // both behind: culled
    send_word(mk(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(mk(1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_word(mk(1, 0, 0, NEAR_Q16, 0, 0, NEAR_Q16 + 1));
    settle();

    // random phases, each with its own camera and one of four idling patterns
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_camera(0, 0, 0, TRIG_ONE, 0, TRIG_ONE, 0, 32'h01_0000);
        1: load_camera($urandom >> 8, $urandom >> 8, $urandom >> 8, rand_trig(),
                       rand_trig(), rand_trig(), rand_trig(), $urandom_range(1, 1 << 20));
        2: load_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFF_FFFF);
        3: load_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, -TRIG_ONE,
                       TRIG_ONE, -TRIG_ONE, -TRIG_ONE, 0);
        default: load_camera($urandom, $urandom, $urandom, $urandom, $urandom,
                             rand_trig(), rand_trig(), $urandom);
      endcase
      // a write to the spare index must change nothing
      reg_write(CFG_IDX_SPARE, $urandom);
      idle_mode = phase % 4;
      repeat (ITEMS / 6) send_word(rand_word());
      settle();
    end

    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
